// File: sv/line_rect_clip_macros.svh
// Assertion macros used by the clipper top level.
`ifndef LINE_RECT_CLIP_MACROS_SVH
`define LINE_RECT_CLIP_MACROS_SVH
`define LRC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: sv/lrc_pkg.sv
// Package with shared constants and types of the line clipper.
package lrc_pkg;
   localparam int COORD_BITS_DEF = 16;
   localparam int COEF_BITS_DEF = 24;
   localparam logic [1:0] REG_LEFT = 2'd0;
   localparam logic [1:0] REG_TOP = 2'd1;
   localparam logic [1:0] REG_RIGHT = 2'd2;
   localparam logic [1:0] REG_BOTTOM = 2'd3;
   typedef struct packed {
      logic valid;
      logic hit;
   } ctl_type;
endpackage

// File: sv/line_rect_clip.sv
// Top level of the line clipper.
// Requests carry one line a*x+b*y+c=0 on req_tdata; each request yields one
// response on rsp_tdata with the hit flag and the two border crossing points.
// The pipeline accepts one request per clock while req_tready is high. After
// the accepting edge, at which the product stage loads, one corner-sign and
// selection stage, 64 divider cells (one per numerator bit), the queue write
// and the output register follow before rsp_tvalid rises.
// Every response enters a 128-entry queue in front of the output register,
// and the pipeline itself never stalls. req_tready drops while the queue
// count plus the responses that may still be in flight could exceed the
// queue, so a stalled receiver backs up the stream without losing requests.
// With the receiver always ready, one response leaves per clock.
// Reset clears all valid bits and the queue and restores the default
// rectangle (0,0)-(1023,767). csr_ writes take effect on later requests; the
// user writes them only while the block is idle, which it does not enforce.
module line_rect_clip
   import lrc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COEF_BITS = COEF_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // coef_a, coef_b, coef_c from bit 0, zero padded
   input  logic [((3*COEF_BITS+COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // hit, first_x, first_y, second_x, second_y from bit 0, zero padded
   output logic [((4*COORD_BITS+1+7)/8)*8-1:0] rsp_tdata,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [COORD_BITS-1:0] csr_wdata
);
   `include "line_rect_clip_macros.svh"
   localparam int CW = COEF_BITS + COORD_BITS;
   localparam int PW = CW + 4;
   localparam int DW = COEF_BITS + 1;
   localparam int NW = 64;
   localparam int LAT = NW;
   localparam int OW = ((4*COORD_BITS+1+7)/8)*8;

   logic signed [COORD_BITS-1:0] left_ff, top_ff, right_ff, bottom_ff;
   logic signed [COEF_BITS-1:0] a, b;
   logic signed [CW-1:0] c;
   logic en;

   assign a = req_tdata[COEF_BITS-1:0];
   assign b = req_tdata[2*COEF_BITS-1:COEF_BITS];
   assign c = req_tdata[3*COEF_BITS+COORD_BITS-1:2*COEF_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         top_ff <= '0;
         right_ff <= COORD_BITS'(1023);
         bottom_ff <= COORD_BITS'(767);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LEFT: left_ff <= csr_wdata;
            REG_TOP: top_ff <= csr_wdata;
            REG_RIGHT: right_ff <= csr_wdata;
            REG_BOTTOM: bottom_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: products.
   logic signed [PW-1:0] ax_l_ff, ax_r_ff, by_t_ff, by_b_ff, c1_ff;
   logic signed [COEF_BITS-1:0] a1_ff, b1_ff;
   logic signed [COORD_BITS-1:0] l1_ff, t1_ff, r1_ff, b1e_ff;
   logic v1_ff;
   // Stage 2: corner signs, selection, numerators.
   logic signed [NW-1:0] n0_in, n1_in, n0_ff, n1_ff;
   logic signed [DW-1:0] d0_in, d1_in, d0_ff, d1_ff;
   logic signed [COORD_BITS-1:0] fx0_in, fy0_in, fx1_in, fy1_in;
   logic sel0x_in, sel1x_in;
   logic hit_in;
   logic signed [PW-1:0] stl, str, sbl, sbr;
   logic signed [PW-1:0] nl, nr, nt, nb;

   // Delay line for fixed coordinates and control.
   logic signed [COORD_BITS-1:0] fx0_d [0:LAT], fy0_d [0:LAT];
   logic signed [COORD_BITS-1:0] fx1_d [0:LAT], fy1_d [0:LAT];
   logic sx0_d [0:LAT], sx1_d [0:LAT];
   ctl_type ctl_d [0:LAT];
   logic signed [COORD_BITS-1:0] q0, q1;

   always_ff @(posedge clock) begin
      if (en) begin
         ax_l_ff <= PW'(a * left_ff);
         ax_r_ff <= PW'(a * right_ff);
         by_t_ff <= PW'(b * top_ff);
         by_b_ff <= PW'(b * bottom_ff);
         c1_ff <= PW'(c);
         a1_ff <= a;
         b1_ff <= b;
         l1_ff <= left_ff;
         t1_ff <= top_ff;
         r1_ff <= right_ff;
         b1e_ff <= bottom_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_tvalid && req_tready;
   end

   always_comb begin
      logic tl, tr, bl, br, el, er, et, eb;
      stl = ax_l_ff + by_t_ff + c1_ff;
      str = ax_r_ff + by_t_ff + c1_ff;
      sbl = ax_l_ff + by_b_ff + c1_ff;
      sbr = ax_r_ff + by_b_ff + c1_ff;
      tl = !stl[PW-1]; tr = !str[PW-1]; bl = !sbl[PW-1]; br = !sbr[PW-1];
      el = tl != bl; er = tr != br; et = tl != tr; eb = bl != br;
      nl = -(ax_l_ff + c1_ff);
      nr = -(ax_r_ff + c1_ff);
      nt = -(by_t_ff + c1_ff);
      nb = -(by_b_ff + c1_ff);
      n0_in = NW'(nl); d0_in = DW'(b1_ff);
      n1_in = NW'(nr); d1_in = DW'(b1_ff);
      fx0_in = l1_ff; fy0_in = t1_ff; fx1_in = r1_ff; fy1_in = t1_ff;
      sel0x_in = 1'b0; sel1x_in = 1'b0;
      hit_in = 1'b1;
      if (el && er) begin
         fx1_in = r1_ff;
      end else if (el || er) begin
         if (er) begin
            fx0_in = r1_ff; n0_in = NW'(nr);
         end
         if (et) begin
            n1_in = NW'(nt); d1_in = DW'(a1_ff); sel1x_in = 1'b1; fy1_in = t1_ff;
         end else begin
            n1_in = NW'(nb); d1_in = DW'(a1_ff); sel1x_in = 1'b1; fy1_in = b1e_ff;
            hit_in = eb;
         end
      end else begin
         n0_in = NW'(nt); d0_in = DW'(a1_ff); sel0x_in = 1'b1; fy0_in = t1_ff;
         n1_in = NW'(nb); d1_in = DW'(a1_ff); sel1x_in = 1'b1; fy1_in = b1e_ff;
         hit_in = et && eb;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n0_ff <= n0_in; d0_ff <= d0_in; n1_ff <= n1_in; d1_ff <= d1_in;
         fx0_d[0] <= fx0_in; fy0_d[0] <= fy0_in;
         fx1_d[0] <= fx1_in; fy1_d[0] <= fy1_in;
         sx0_d[0] <= sel0x_in; sx1_d[0] <= sel1x_in;
         ctl_d[0].hit <= hit_in;
      end
      if (reset) ctl_d[0].valid <= 1'b0;
      else if (en) ctl_d[0].valid <= v1_ff;
   end

   for (genvar g = 0; g < LAT; g++) begin : g_dly
      always_ff @(posedge clock) begin
         if (en) begin
            fx0_d[g+1] <= fx0_d[g]; fy0_d[g+1] <= fy0_d[g];
            fx1_d[g+1] <= fx1_d[g]; fy1_d[g+1] <= fy1_d[g];
            sx0_d[g+1] <= sx0_d[g]; sx1_d[g+1] <= sx1_d[g];
            ctl_d[g+1].hit <= ctl_d[g].hit;
         end
         if (reset) ctl_d[g+1].valid <= 1'b0;
         else if (en) ctl_d[g+1].valid <= ctl_d[g].valid;
      end
   end

   // The dividers have no enable; their quotients line up with the end of
   // the delay line.
   logic signed [NW-1:0] n0_g, n1_g;
   logic signed [DW-1:0] d0_g, d1_g;
   assign n0_g = n0_ff; assign d0_g = d0_ff; assign n1_g = n1_ff; assign d1_g = d1_ff;

   lrc_divider #(.NW(NW), .DW(DW), .QW(COORD_BITS)) u_div0 (
      .clock(clock), .num(n0_g), .den(d0_g), .quo(q0));
   lrc_divider #(.NW(NW), .DW(DW), .QW(COORD_BITS)) u_div1 (
      .clock(clock), .num(n1_g), .den(d1_g), .quo(q1));

   // The divider is free-running, so the pipeline never stalls: the skid
   // queue below is deep enough for every response in flight.
   assign en = 1'b1;
   localparam int QD = 128;
   logic [OW-1:0] q_mem [0:QD-1];
   logic [6:0] wp_ff, rp_ff;
   logic [7:0] cnt_ff;
   logic [OW-1:0] wdat;
   logic [OW-1:0] rdat_ff;
   logic rv_ff;
   ctl_type fin;
   logic push, pop, load;

   assign fin = ctl_d[LAT];
   always_comb begin
      wdat = '0;
      if (fin.hit) begin
         wdat[0] = 1'b1;
         wdat[COORD_BITS:1] = sx0_d[LAT] ? q0 : fx0_d[LAT];
         wdat[2*COORD_BITS:COORD_BITS+1] = sx0_d[LAT] ? fy0_d[LAT] : q0;
         wdat[3*COORD_BITS:2*COORD_BITS+1] = sx1_d[LAT] ? q1 : fx1_d[LAT];
         wdat[4*COORD_BITS:3*COORD_BITS+1] = sx1_d[LAT] ? fy1_d[LAT] : q1;
      end
   end

   assign push = fin.valid;
   assign load = (cnt_ff != 8'd0) && (!rv_ff || rsp_tready);
   assign pop = load;
   assign req_tready = (cnt_ff + 8'(LAT + 2)) < 8'(QD);

   always_ff @(posedge clock) begin
      if (push) q_mem[wp_ff] <= wdat;
      if (load) rdat_ff <= q_mem[rp_ff];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; rv_ff <= 1'b0;
      end else begin
         if (push) wp_ff <= wp_ff + 7'd1;
         if (pop) rp_ff <= rp_ff + 7'd1;
         cnt_ff <= cnt_ff + 8'(push) - 8'(pop);
         if (load) rv_ff <= 1'b1;
         else if (rsp_tready) rv_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rdat_ff;

   `LRC_ASSERT_IMPL(a_no_overflow, clock, reset, push, cnt_ff < 8'(QD))
   `LRC_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `LRC_ASSERT_IMPL(a_miss_zero, clock, reset, push && !fin.hit, wdat == '0)
endmodule

// File: sv/lrc_div_cell.sv
// One restoring division cell: produces one quotient bit per pipeline stage.
module lrc_div_cell
   import lrc_pkg::*;
#(
   parameter int NW = 64,
   parameter int DW = 33,
   parameter int BIT = 0
) (
   input  logic          clock,
   input  logic [NW-1:0] num_in,
   input  logic [DW-1:0] den_in,
   input  logic [DW:0]   rem_in,
   input  logic [NW-1:0] quo_in,
   output logic [NW-1:0] num_ff,
   output logic [DW-1:0] den_ff,
   output logic [DW:0]   rem_ff,
   output logic [NW-1:0] quo_ff
);
   logic [DW+1:0] shifted;
   logic [DW+1:0] diff;
   logic [DW:0]   rem_nx;
   logic [NW-1:0] quo_nx;

   always_comb begin
      shifted = {rem_in, num_in[BIT]};
      diff = shifted - {2'b00, den_in};
      quo_nx = quo_in;
      if (!diff[DW+1]) begin
         rem_nx = diff[DW:0];
         quo_nx[BIT] = 1'b1;
      end else begin
         rem_nx = shifted[DW:0];
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_nx;
      quo_ff <= quo_nx;
   end
endmodule

// File: sv/lrc_divider.sv
// Pipelined signed divider built from a chain of one-bit cells, truncating toward zero.
module lrc_divider
   import lrc_pkg::*;
#(
   parameter int NW = 64,
   parameter int DW = 33,
   parameter int QW = 16
) (
   input  logic                 clock,
   input  logic signed [NW-1:0] num,
   input  logic signed [DW-1:0] den,
   output logic signed [QW-1:0] quo
);
   localparam int STAGES = NW;
   logic [NW-1:0] num_s [0:STAGES];
   logic [DW-1:0] den_s [0:STAGES];
   logic [DW:0]   rem_s [0:STAGES];
   logic [NW-1:0] quo_s [0:STAGES];
   logic          neg_s [0:STAGES];
   logic          zero_s [0:STAGES];
   logic [NW-1:0] q_mag;

   always_comb begin
      num_s[0] = num[NW-1] ? NW'(-num) : NW'(num);
      den_s[0] = den[DW-1] ? DW'(-den) : DW'(den);
      rem_s[0] = '0;
      quo_s[0] = '0;
      neg_s[0] = num[NW-1] ^ den[DW-1];
      zero_s[0] = (den == '0);
   end

   for (genvar g = 0; g < STAGES; g++) begin : g_cell
      lrc_div_cell #(.NW(NW), .DW(DW), .BIT(NW-1-g)) u_cell (
         .clock(clock), .num_in(num_s[g]), .den_in(den_s[g]), .rem_in(rem_s[g]),
         .quo_in(quo_s[g]), .num_ff(num_s[g+1]), .den_ff(den_s[g+1]),
         .rem_ff(rem_s[g+1]), .quo_ff(quo_s[g+1]));
      always_ff @(posedge clock) begin
         neg_s[g+1] <= neg_s[g];
         zero_s[g+1] <= zero_s[g];
      end
   end

   assign q_mag = neg_s[STAGES] ? NW'(-quo_s[STAGES]) : quo_s[STAGES];
   assign quo = zero_s[STAGES] ? '0 : QW'(q_mag);
endmodule
